/* rtl/adjacency_matrix_graph_engine_unit_defines.svh */
// Assertion macros for the adjacency matrix graph engine.
// Included by the top level; depends on nothing else.
`ifndef ADJACENCY_MATRIX_GRAPH_ENGINE_UNIT_DEFINES_SVH
`define ADJACENCY_MATRIX_GRAPH_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, held off during reset
`define AMGE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset
`define AMGE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/amge_pkg.sv */
// Shared types and constants for the adjacency matrix graph engine.
// No dependencies; used by amge_ctrl, amge_dpath and the top level.
package amge_pkg;

  localparam int MAX_VERTICES_DEF = 16;

  // Command codes
  localparam logic [2:0] CMD_ADD_VERTEX    = 3'd0;
  localparam logic [2:0] CMD_ADD_EDGE      = 3'd1;
  localparam logic [2:0] CMD_REMOVE_EDGE   = 3'd2;
  localparam logic [2:0] CMD_REMOVE_VERTEX = 3'd3;
  localparam logic [2:0] CMD_READ_EDGE     = 3'd4;

  // Configuration register byte addresses
  localparam logic [2:0] ADDR_DIRECTED_MODE = 3'd0;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [3:0]         vertex_a;
    logic [3:0]         vertex_b;
    logic signed [15:0] edge_weight_in;
  } cmd_item_t;

  typedef struct packed {
    logic               ok;
    logic signed [15:0] edge_weight_out;
    logic               graph_empty;
    logic [4:0]         vertex_total;
  } rsp_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_MIRROR,
    ST_READ,
    ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic exec;
    logic mirror;
    logic clear_step;
    logic load_read;
    logic load_out;
  } amge_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] cmd;
    logic       cmd_ok;
    logic       directed;
    logic       clear_last;
  } amge_sts_t;

endpackage

/* rtl/amge_ctrl.sv */
// Sequencing state machine for the adjacency matrix graph engine.
// Depends on amge_pkg; drives amge_dpath through amge_ctl_t.
module amge_ctrl
  import amge_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  input  amge_sts_t sts,
  output amge_ctl_t ctl
);

  state_t state;
  state_t state_next;
  logic   out_free;

  // Output register can take a new beat when empty or being drained
  assign out_free = !rsp_valid || !rsp_stall;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_DONE;
        if (sts.cmd_ok) begin
          case (sts.cmd)
            CMD_ADD_VERTEX:  state_next = ST_CLEAR;
            CMD_ADD_EDGE,
            CMD_REMOVE_EDGE: state_next = sts.directed ? ST_DONE : ST_MIRROR;
            CMD_READ_EDGE:   state_next = ST_READ;
            default:         state_next = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (sts.clear_last) state_next = ST_DONE;
      end
      ST_MIRROR: state_next = ST_DONE;
      ST_READ:   state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    ctl            = '0;
    cmd_stall      = 1'b1;
    case (state)
      ST_IDLE: begin
        cmd_stall     = 1'b0;
        ctl.load_item = cmd_valid;
      end
      ST_EXEC:   ctl.exec       = 1'b1;
      ST_CLEAR:  ctl.clear_step = 1'b1;
      ST_MIRROR: ctl.mirror     = 1'b1;
      ST_READ:   ctl.load_read  = 1'b1;
      ST_DONE:   ctl.load_out   = out_free;
      default: begin
        cmd_stall = 1'b1;
      end
    endcase
  end

  // Hold result valid until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

/* rtl/amge_dpath.sv */
// Datapath of the adjacency matrix graph engine: command register, vertex
// bitmap and count, weight matrix memory, row/column sweep and result register.
// Depends on amge_pkg; controlled by amge_ctrl.
module amge_dpath
  import amge_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  amge_ctl_t ctl,
  input  logic      directed,
  input  cmd_item_t cmd_item,
  output amge_sts_t sts,
  output rsp_item_t rsp_item
);

  localparam int VW        = $clog2(MAX_VERTICES);
  localparam int AW        = 2 * VW;
  localparam int MEM_DEPTH = 1 << AW;
  localparam int CW        = $clog2(MAX_VERTICES + 1);
  localparam logic [VW:0] SWEEP_LAST = (VW + 1)'(2 * MAX_VERTICES - 1);

  cmd_item_t          item;
  logic [MAX_VERTICES-1:0] present;
  logic [CW-1:0]      count;
  logic [VW:0]        sweep_cnt;
  logic [VW-1:0]      sweep_idx;
  logic [VW-1:0]      a_idx;
  logic [VW-1:0]      b_idx;
  logic               a_here;
  logic               b_here;
  logic               cmd_ok;
  logic signed [15:0] edge_data;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [15:0] wr_data;
  logic signed [15:0] rd_data;
  logic               res_ok;
  logic signed [15:0] res_weight;
  logic signed [15:0] mem [MEM_DEPTH];

  // Capture the command beat
  always_ff @(posedge clk) begin
    if (ctl.load_item) item <= cmd_item;
  end

  assign a_idx     = VW'(item.vertex_a);
  assign b_idx     = VW'(item.vertex_b);
  assign sweep_idx = sweep_cnt[VW:1];

  // Presence checks; an id beyond the vertex range is never present
  assign a_here = ({28'd0, item.vertex_a} < 32'(MAX_VERTICES)) && present[a_idx];
  assign b_here = ({28'd0, item.vertex_b} < 32'(MAX_VERTICES)) && present[b_idx];

  always_comb begin
    case (item.cmd)
      CMD_ADD_VERTEX:    cmd_ok = ({28'd0, item.vertex_a} < 32'(MAX_VERTICES))
                                  && !present[a_idx];
      CMD_ADD_EDGE,
      CMD_REMOVE_EDGE,
      CMD_READ_EDGE:     cmd_ok = a_here && b_here;
      CMD_REMOVE_VERTEX: cmd_ok = a_here;
      default:           cmd_ok = 1'b0;
    endcase
  end

  assign edge_data = (item.cmd == CMD_ADD_EDGE) ? item.edge_weight_in : 16'sd0;

  // Update the vertex bitmap and count
  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      count   <= '0;
    end else if (ctl.exec && cmd_ok) begin
      case (item.cmd)
        CMD_ADD_VERTEX: begin
          present[a_idx] <= 1'b1;
          count          <= count + CW'(1);
        end
        CMD_REMOVE_VERTEX: begin
          present[a_idx] <= 1'b0;
          count          <= count - CW'(1);
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  // Row then column entry per slot: even steps clear row, odd steps column
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (ctl.exec) begin
      sweep_cnt <= '0;
    end else if (ctl.clear_step) begin
      sweep_cnt <= sweep_cnt + (VW + 1)'(1);
    end
  end

  // Select the single matrix write
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {a_idx, b_idx};
    wr_data = edge_data;
    if (ctl.clear_step) begin
      wr_en   = 1'b1;
      wr_addr = sweep_cnt[0] ? {sweep_idx, a_idx} : {a_idx, sweep_idx};
      wr_data = 16'sd0;
    end else if (ctl.mirror) begin
      wr_en   = 1'b1;
      wr_addr = {b_idx, a_idx};
    end else if (ctl.exec && cmd_ok &&
                 (item.cmd == CMD_ADD_EDGE || item.cmd == CMD_REMOVE_EDGE)) begin
      wr_en   = 1'b1;
    end
  end

  // Weight matrix: one write port, registered read at the command's entry
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[{a_idx, b_idx}];
  end

  // Result fields
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      res_ok     <= cmd_ok;
      res_weight <= 16'sd0;
    end else if (ctl.load_read) begin
      res_weight <= rd_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      rsp_item.ok              <= res_ok;
      rsp_item.edge_weight_out <= res_weight;
      rsp_item.graph_empty     <= (count == '0);
      rsp_item.vertex_total    <= 5'(count);
    end
  end

  assign sts.cmd        = item.cmd;
  assign sts.cmd_ok     = cmd_ok;
  assign sts.directed   = directed;
  assign sts.clear_last = (sweep_cnt == SWEEP_LAST);

endmodule

/* rtl/adjacency_matrix_graph_engine_unit.sv */
// Top level of the adjacency matrix graph engine: APB register, controller
// and datapath. Depends on amge_pkg, amge_ctrl, amge_dpath and the defines header.
//
//   channel | dir | handshake               | beat
//   --------+-----+-------------------------+------------
//   cmd     | in  | cmd_valid / cmd_stall   | cmd_item_t
//   rsp     | out | rsp_valid / rsp_stall   | rsp_item_t
//   apb     | in  | psel/penable/pready     | 32-bit reg
//
// One command at a time. A successful add vertex is the longest command, set by the
// row and column sweep through the matrix's single write port.
// A successful mirrored edge write adds a mirror state, and a successful read edge a read state.
// Reset is synchronous; no clearing pass: rows and columns are zeroed when a
// vertex is added, so an entry between present vertices is always written.
// A result waits in the output register while rsp_stall is high; the next
// command is accepted meanwhile and completes once that register drains.
`include "adjacency_matrix_graph_engine_unit_defines.svh"

module adjacency_matrix_graph_engine_unit
  import amge_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  cmd_item_t   cmd_item,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_item_t   rsp_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic      directed_mode;
  amge_ctl_t ctl;
  amge_sts_t sts;
  logic      cmd_beat;
  logic      empty_ok;
  logic      weight_seen;

  assign pready = 1'b1;

  // Configuration register write
  always_ff @(posedge clk) begin
    if (rst) begin
      directed_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == ADDR_DIRECTED_MODE[2]) begin
      directed_mode <= pwdata[0];
    end
  end

  // Register readback
  assign prdata = (paddr[2] == ADDR_DIRECTED_MODE[2]) ? {31'd0, directed_mode} : 32'd0;

  amge_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  amge_dpath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .directed (directed_mode),
    .cmd_item (cmd_item),
    .sts      (sts),
    .rsp_item (rsp_item)
  );

  // Checks
  assign cmd_beat    = cmd_valid && !cmd_stall;
  assign empty_ok    = (rsp_item.graph_empty == (rsp_item.vertex_total == 5'd0));
  assign weight_seen = rsp_valid && (rsp_item.edge_weight_out != 16'sd0);

  `AMGE_ASSERT_NEXT(a_busy_after_accept, clk, rst, cmd_beat, cmd_stall, "accepted while busy")
  `AMGE_ASSERT_NOW(a_empty_flag, clk, rst, rsp_valid, empty_ok, "empty flag mismatch")
  `AMGE_ASSERT_NOW(a_weight_ok, clk, rst, weight_seen, rsp_item.ok, "weight on failed command")

endmodule

/* tb/amge_graph_checker.sv */
// Response checker for the adjacency matrix graph engine: shadows the graph,
// predicts one response per command beat and compares it field by field.
// Depends on amge_pkg.
module amge_graph_checker
  import amge_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  logic        cmd_stall,
  input  cmd_item_t   cmd_item,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  rsp_item_t   rsp_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int unsigned pending,
  output int unsigned mismatches
);

  localparam int NV = MAX_VERTICES_DEF;

  // Shadow copy of the graph and its mode register
  logic               directed;
  logic [NV-1:0]      present;
  logic [4:0]         vertex_count;
  logic signed [15:0] weight_grid [NV][NV];
  rsp_item_t          predicted_rsp_q [$];
  int unsigned        fail_tally = 0;

  // Write one entry, and its transpose when the graph is undirected
  task automatic store_weight(input logic [3:0] a, input logic [3:0] b,
                              input logic signed [15:0] w);
    weight_grid[a][b] = w;
    if (!directed) weight_grid[b][a] = w;
  endtask

  // Apply one command to the shadow graph and build its response
  task automatic apply_graph_cmd(input cmd_item_t c, output rsp_item_t r);
    logic a_here;
    logic b_here;
    a_here = present[c.vertex_a];
    b_here = present[c.vertex_b];
    r = '0;
    case (c.cmd)
      CMD_ADD_VERTEX: begin
        if (!a_here) begin
          present[c.vertex_a] = 1'b1;
          vertex_count++;
          r.ok = 1'b1;
        end
      end
      CMD_ADD_EDGE: begin
        if (a_here && b_here) begin
          store_weight(c.vertex_a, c.vertex_b, c.edge_weight_in);
          r.ok = 1'b1;
        end
      end
      CMD_REMOVE_EDGE: begin
        if (a_here && b_here) begin
          store_weight(c.vertex_a, c.vertex_b, '0);
          r.ok = 1'b1;
        end
      end
      CMD_REMOVE_VERTEX: begin
        if (a_here) begin
          // drop the whole row and column
          for (int i = 0; i < NV; i++) begin
            weight_grid[c.vertex_a][i] = '0;
            weight_grid[i][c.vertex_a] = '0;
          end
          present[c.vertex_a] = 1'b0;
          if (vertex_count != 0) vertex_count--;
          r.ok = 1'b1;
        end
      end
      CMD_READ_EDGE: begin
        if (a_here && b_here) begin
          r.edge_weight_out = weight_grid[c.vertex_a][c.vertex_b];
          r.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.graph_empty  = (vertex_count == 0);
    r.vertex_total = vertex_count;
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_tally++;
    end
  endtask

  always @(posedge clk) begin
    rsp_item_t want;
    if (rst) begin
      directed     = 1'b0;
      present      = '0;
      vertex_count = '0;
      for (int i = 0; i < NV; i++)
        for (int j = 0; j < NV; j++)
          weight_grid[i][j] = '0;
      predicted_rsp_q.delete();
    end else begin
      // Register access: track writes, check reads
      if (psel && penable && pready && paddr == ADDR_DIRECTED_MODE) begin
        if (pwrite) directed = pwdata[0];
        else check_field("directed_mode", longint'(directed), longint'(prdata[0]));
      end
      // Retire the oldest prediction against each response beat
      if (rsp_valid && !rsp_stall) begin
        if (predicted_rsp_q.size() == 0) begin
          $error("response beat with no command outstanding");
          fail_tally++;
        end else begin
          want = predicted_rsp_q.pop_front();
          check_field("ok", longint'(want.ok), longint'(rsp_item.ok));
          check_field("edge_weight_out", longint'(want.edge_weight_out),
                      longint'(rsp_item.edge_weight_out));
          check_field("graph_empty", longint'(want.graph_empty),
                      longint'(rsp_item.graph_empty));
          check_field("vertex_total", longint'(want.vertex_total),
                      longint'(rsp_item.vertex_total));
        end
      end
      // Predict the response of each accepted command beat
      if (cmd_valid && !cmd_stall) begin
        apply_graph_cmd(cmd_item, want);
        predicted_rsp_q.push_back(want);
      end
    end
    pending    <= predicted_rsp_q.size();
    mismatches <= fail_tally;
  end

endmodule

/* tb/adjacency_matrix_graph_engine_unit_test.sv */
// Stimulus top for the adjacency matrix graph engine: directed corner cases,
// then random command phases in both graph modes with random idling.
// Depends on amge_pkg, the engine RTL and amge_graph_checker.
module adjacency_matrix_graph_engine_unit_test;
  import amge_pkg::*;

  localparam int unsigned IDLE_LIMIT      = 2000;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned ITEMS_PER_PHASE = 175;
  // add vertex sweeps a row and a column
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam logic [2:0]  CMD_BAD_FIRST   = CMD_READ_EDGE + 3'd1;
  localparam logic [2:0]  CMD_BAD_LAST    = 3'd7;

  typedef enum int {MIX_BUILD, MIX_NORMAL, MIX_TEARDOWN} cmd_mix_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  cmd_item_t   cmd_item  = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_item_t   rsp_item;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;
  int unsigned pending;
  int unsigned mismatches;

  logic        sink_quiet  = 1'b0;
  bit          burst_mode  = 1'b0;
  int unsigned stall_left  = 0;
  int unsigned idle_cycles = 0;

  adjacency_matrix_graph_engine_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  amge_graph_checker checker_i (.*);

  always #6 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Response-side stall bursts
  always @(posedge clk) begin
    if (rst || sink_quiet) stall_left = 0;
    else if (stall_left != 0) stall_left--;
    else if ($urandom_range(0, 4) == 0) stall_left = pick_gap();
    rsp_stall <= (stall_left != 0);
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || (psel && penable && pready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // One register transfer: setup, access, then back to idle
  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Present one command beat after an optional gap; return once accepted
  task automatic send_cmd(input logic [2:0] op, input logic [3:0] va, input logic [3:0] vb,
                          input logic [15:0] wt);
    cmd_item_t   beat;
    int unsigned gap;
    beat.cmd            = op;
    beat.vertex_a       = va;
    beat.vertex_b       = vb;
    beat.edge_weight_in = wt;
    gap = burst_mode ? 0 : pick_gap();
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_item  <= beat;
    do @(posedge clk); while (cmd_stall);
  endtask

  // Hold off commands until every response is back
  task automatic drain_results();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Random command with a mix of operations that depends on the phase
  task automatic send_random(input cmd_mix_t mix);
    int unsigned r;
    int unsigned cut [5];
    logic [2:0]  op;
    logic [15:0] wt;
    case (mix)
      MIX_BUILD:    cut = '{45, 70, 75, 78, 97};
      MIX_TEARDOWN: cut = '{6, 20, 30, 60, 97};
      default:      cut = '{15, 45, 57, 65, 96};
    endcase
    r = $urandom_range(0, 99);
    if (r < cut[0])      op = CMD_ADD_VERTEX;
    else if (r < cut[1]) op = CMD_ADD_EDGE;
    else if (r < cut[2]) op = CMD_REMOVE_EDGE;
    else if (r < cut[3]) op = CMD_REMOVE_VERTEX;
    else if (r < cut[4]) op = CMD_READ_EDGE;
    else                 op = 3'($urandom_range(CMD_BAD_LAST, CMD_BAD_FIRST));
    // weights: some zero, some extremes, the rest anything
    r = $urandom_range(0, 99);
    if (r < 8) begin
      wt = '0;
    end else if (r < 16) begin
      case ($urandom_range(0, 3))
        0:       wt = 16'h7FFF;
        1:       wt = 16'h8000;
        2:       wt = 16'hFFFF;
        default: wt = 16'h0001;
      endcase
    end else begin
      wt = 16'($urandom);
    end
    send_cmd(op, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), wt);
  endtask

  initial begin
    cmd_mix_t mix;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corner cases, undirected graph
    apb_access(1'b1, ADDR_DIRECTED_MODE, 32'd0);
    send_cmd(CMD_READ_EDGE, 4'd0, 4'd0, 16'h0000);       // empty graph
    send_cmd(CMD_ADD_VERTEX, 4'd0, 4'd0, 16'h0000);
    send_cmd(CMD_ADD_VERTEX, 4'd15, 4'd0, 16'h0000);
    send_cmd(CMD_ADD_VERTEX, 4'd15, 4'd3, 16'h0000);     // already present
    send_cmd(CMD_ADD_EDGE, 4'd0, 4'd15, 16'h7FFF);
    send_cmd(CMD_READ_EDGE, 4'd15, 4'd0, 16'h0000);      // mirrored entry
    send_cmd(CMD_ADD_EDGE, 4'd15, 4'd15, 16'h8000);      // self loop
    send_cmd(CMD_READ_EDGE, 4'd15, 4'd15, 16'h0000);
    send_cmd(CMD_ADD_EDGE, 4'd0, 4'd15, 16'h0000);       // zero weight
    send_cmd(CMD_READ_EDGE, 4'd0, 4'd15, 16'h0000);
    send_cmd(CMD_ADD_EDGE, 4'd0, 4'd9, 16'h1234);        // absent endpoint
    send_cmd(CMD_REMOVE_EDGE, 4'd9, 4'd0, 16'h0000);
    send_cmd(CMD_READ_EDGE, 4'd9, 4'd9, 16'h0000);
    send_cmd(CMD_REMOVE_VERTEX, 4'd9, 4'd0, 16'h0000);
    send_cmd(CMD_BAD_FIRST, 4'd0, 4'd15, 16'hFFFF);      // unknown commands
    send_cmd(CMD_BAD_FIRST + 3'd1, 4'd15, 4'd0, 16'h0001);
    send_cmd(CMD_BAD_LAST, 4'd0, 4'd0, 16'h7FFF);
    send_cmd(CMD_ADD_EDGE, 4'd15, 4'd0, 16'hFFFF);
    send_cmd(CMD_REMOVE_EDGE, 4'd0, 4'd15, 16'h0000);
    send_cmd(CMD_READ_EDGE, 4'd15, 4'd0, 16'h0000);
    send_cmd(CMD_ADD_EDGE, 4'd0, 4'd15, 16'h5A5A);
    send_cmd(CMD_REMOVE_VERTEX, 4'd15, 4'd0, 16'h0000);
    send_cmd(CMD_REMOVE_VERTEX, 4'd15, 4'd0, 16'h0000);  // already gone
    send_cmd(CMD_ADD_VERTEX, 4'd15, 4'd0, 16'h0000);
    send_cmd(CMD_READ_EDGE, 4'd0, 4'd15, 16'h0000);      // cleared when vertex 15 is added again
    send_cmd(CMD_REMOVE_VERTEX, 4'd0, 4'd0, 16'h0000);
    send_cmd(CMD_REMOVE_VERTEX, 4'd15, 4'd0, 16'h0000);  // back to empty
    drain_results();

    // Random phases, alternating directed and undirected mode
    for (int p = 0; p < PHASES; p++) begin
      apb_access(1'b1, ADDR_DIRECTED_MODE, (p % 2 == 0) ? 32'd1 : 32'd0);
      apb_access(1'b0, ADDR_DIRECTED_MODE, 32'd0);
      burst_mode = (p == 2);
      sink_quiet <= (p == 2);
      if (p == 0 || p == 4)      mix = MIX_BUILD;
      else if (p == 3 || p == 5) mix = MIX_TEARDOWN;
      else                       mix = MIX_NORMAL;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 1 && n == ITEMS_PER_PHASE / 2) drain_results();
        send_random(mix);
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
